// File: sv/dali_dm_pkg.sv
// shared types, constants and helpers for the dual-line dali master
`timescale 1ns / 1ps
`default_nettype none

package dali_dm_pkg;

    // frame geometry
    localparam int FORWARD_BITS = 16;
    localparam int ANSWER_BITS  = 8;
    localparam int FWD_IDX_W    = $clog2(FORWARD_BITS);
    localparam int POS_W        = 6;
    localparam int RX_POS_W     = 5;
    localparam int WIN_W        = 6;

    // half-bit positions of the forward frame
    localparam logic [POS_W-1:0] DATA_END = POS_W'(2 * FORWARD_BITS + 1);
    localparam logic [POS_W-1:0] OPEN_POS = POS_W'(2 * FORWARD_BITS + 5);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(2 * FORWARD_BITS + 13);

    // receive positions of the backward frame
    localparam logic [RX_POS_W-1:0] RX_LAST_EDGE = RX_POS_W'(2 * ANSWER_BITS);
    localparam logic [RX_POS_W-1:0] RX_DONE_POS  = RX_POS_W'(2 * ANSWER_BITS + 1);

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(27);

    // item kinds carried in tuser
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_EDGE  = 2'd2;

    // stream widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [1:0]              mode;
        logic [FORWARD_BITS-1:0] frame_line_a;
        logic [FORWARD_BITS-1:0] frame_line_b;
        logic                    rx_level;
    } item_t;

    // input stage to engine handshake
    typedef struct packed {
        logic  valid;
        item_t item;
    } item_bus_t;

    typedef struct packed {
        logic                   no_answer;
        logic                   answer_valid;
        logic [ANSWER_BITS-1:0] answer_byte;
        logic                   busy_res;
        logic                   line_b_level;
        logic                   line_a_level;
    } result_t;

    // level of one manchester half-bit, msb first, first half inverted
    function automatic logic manchester_level(input logic [FORWARD_BITS-1:0] frame,
                                              input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] diff;
        diff = POS_W'(2 * FORWARD_BITS) - pos;
        return frame[diff[FWD_IDX_W:1]] ^ pos[0];
    endfunction

endpackage

`default_nettype wire

// File: sv/dali_dm_in_stage.sv
// input register of the dali master stream
`timescale 1ns / 1ps
`default_nettype none

module dali_dm_in_stage (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [dali_dm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic [1:0]                          s_axis_tuser,
    input  wire logic                                advance,
    output dali_dm_pkg::item_bus_t                   item_bus
);
    import dali_dm_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // unpack the transaction into the item register
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.mode         <= s_axis_tuser;
            item_reg.frame_line_a <= s_axis_tdata[FORWARD_BITS-1:0];
            item_reg.frame_line_b <= s_axis_tdata[2*FORWARD_BITS-1:FORWARD_BITS];
            item_reg.rx_level     <= s_axis_tdata[2*FORWARD_BITS];
        end
    end

    assign item_bus.valid = in_valid_reg;
    assign item_bus.item  = item_reg;

endmodule

`default_nettype wire

// File: sv/dali_dm_engine.sv
// transfer state, next-state logic and result register of the dali master
`timescale 1ns / 1ps
`default_nettype none

module dali_dm_engine (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [dali_dm_pkg::WIN_W-1:0]      cfg_wr_data,
    input  wire dali_dm_pkg::item_bus_t             item_bus,
    output logic                                    advance,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [dali_dm_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import dali_dm_pkg::*;

    logic [WIN_W-1:0]              win_cfg_reg;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          tx_active_reg, tx_active_next;
    logic                          busy_reg, busy_next;
    logic                          lvl_a_reg, lvl_a_next;
    logic                          lvl_b_reg, lvl_b_next;
    logic [FORWARD_BITS-1:0]       fwd_a_reg, fwd_a_next;
    logic [FORWARD_BITS-1:0]       fwd_b_reg, fwd_b_next;
    logic [RX_POS_W-1:0]           rx_pos_reg, rx_pos_next;
    logic                          rx_active_reg, rx_active_next;
    logic [ANSWER_BITS-1:0]        rx_shift_reg, rx_shift_next;
    logic                          pol_reg, pol_next;
    logic [WIN_W-1:0]              win_reg, win_next;
    logic                          held_a_reg, held_a_next;
    logic                          held_b_reg, held_b_next;
    logic [ANSWER_BITS-1:0]        answer_reg, answer_next;
    logic                          answered_reg, answered_next;
    logic                          out_valid_reg, out_valid_next;
    result_t                       result_reg, result_next;
    logic                          fire;
    logic                          got_answer;
    logic                          no_ans;
    item_t                         it;

    assign it      = item_bus.item;
    assign advance = !out_valid_reg || m_axis_tready;
    assign fire    = item_bus.valid && advance;

    // next state for the item in the input register
    always_comb
    begin
        pos_next       = pos_reg;
        tx_active_next = tx_active_reg;
        busy_next      = busy_reg;
        lvl_a_next     = lvl_a_reg;
        lvl_b_next     = lvl_b_reg;
        fwd_a_next     = fwd_a_reg;
        fwd_b_next     = fwd_b_reg;
        rx_pos_next    = rx_pos_reg;
        rx_active_next = rx_active_reg;
        rx_shift_next  = rx_shift_reg;
        pol_next       = pol_reg;
        win_next       = win_reg;
        held_a_next    = held_a_reg;
        held_b_next    = held_b_reg;
        answer_next    = answer_reg;
        answered_next  = answered_reg;
        got_answer     = 1'b0;
        no_ans         = 1'b0;
        if (fire)
        begin
            case (it.mode)
                MODE_START:
                begin
                    // ignored while a transfer runs
                    if (!busy_reg)
                    begin
                        fwd_a_next     = it.frame_line_a;
                        fwd_b_next     = it.frame_line_b;
                        lvl_a_next     = 1'b0;
                        lvl_b_next     = 1'b0;
                        pos_next       = '0;
                        win_next       = '0;
                        rx_shift_next  = '0;
                        rx_active_next = 1'b0;
                        answered_next  = 1'b0;
                        busy_next      = 1'b1;
                        tx_active_next = 1'b1;
                    end
                end
                MODE_TICK:
                begin
                    if (tx_active_reg)
                    begin
                        // drive the level computed on the previous tick
                        held_a_next = lvl_a_reg;
                        held_b_next = lvl_b_reg;
                        if (pos_reg == '0)
                        begin
                            lvl_a_next = 1'b1;
                            lvl_b_next = 1'b1;
                        end
                        else if (pos_reg < DATA_END)
                        begin
                            lvl_a_next = manchester_level(fwd_a_reg, pos_reg);
                            lvl_b_next = manchester_level(fwd_b_reg, pos_reg);
                        end
                        else if (pos_reg == DATA_END)
                        begin
                            lvl_a_next = 1'b1;
                            lvl_b_next = 1'b1;
                        end
                        else if (pos_reg == OPEN_POS)
                        begin
                            rx_pos_next = '0;
                            win_next    = (win_cfg_reg == '0) ? WIN_W'(1) : win_cfg_reg;
                        end
                        // answer window countdown
                        if (win_next > WIN_W'(1))
                        begin
                            win_next = win_next - WIN_W'(1);
                        end
                        else if (win_next == WIN_W'(1))
                        begin
                            tx_active_next = 1'b0;
                            rx_active_next = 1'b0;
                            busy_next      = 1'b0;
                            win_next       = '0;
                            no_ans         = !answered_reg;
                        end
                        if (pos_reg < LAST_POS)
                        begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end
                    // receive sampling, or end of reception
                    if (rx_active_next)
                    begin
                        if (rx_pos_next < RX_DONE_POS)
                        begin
                            pol_next    = it.rx_level;
                            rx_pos_next = rx_pos_next + RX_POS_W'(1);
                        end
                        else
                        begin
                            tx_active_next = 1'b0;
                            rx_active_next = 1'b0;
                            busy_next      = 1'b0;
                            win_next       = '0;
                            rx_pos_next    = '0;
                            rx_shift_next  = '0;
                            lvl_a_next     = 1'b0;
                            lvl_b_next     = 1'b0;
                        end
                    end
                end
                MODE_EDGE:
                begin
                    // only while listening
                    if (win_reg != '0 || rx_active_reg)
                    begin
                        if (rx_pos_reg == '0)
                        begin
                            rx_pos_next = RX_POS_W'(1);
                        end
                        else if (rx_pos_reg == RX_POS_W'(1))
                        begin
                            rx_active_next = 1'b1;
                        end
                        else if (!rx_pos_reg[0] && rx_pos_reg <= RX_LAST_EDGE)
                        begin
                            rx_shift_next = {rx_shift_reg[ANSWER_BITS-2:0], !pol_reg};
                            if (rx_pos_reg == RX_LAST_EDGE)
                            begin
                                answer_next   = rx_shift_next;
                                answered_next = 1'b1;
                                got_answer    = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result of this item
    always_comb
    begin
        result_next.line_a_level = held_a_next;
        result_next.line_b_level = held_b_next;
        result_next.busy_res     = busy_next;
        result_next.answer_byte  = answer_next;
        result_next.answer_valid = got_answer;
        result_next.no_answer    = no_ans;
        out_valid_next           = fire || (out_valid_reg && !m_axis_tready);
    end

    // control and transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cfg_reg   <= WIN_RESET;
            pos_reg       <= '0;
            tx_active_reg <= 1'b0;
            busy_reg      <= 1'b0;
            lvl_a_reg     <= 1'b0;
            lvl_b_reg     <= 1'b0;
            fwd_a_reg     <= '0;
            fwd_b_reg     <= '0;
            rx_pos_reg    <= '0;
            rx_active_reg <= 1'b0;
            rx_shift_reg  <= '0;
            pol_reg       <= 1'b0;
            win_reg       <= '0;
            held_a_reg    <= 1'b0;
            held_b_reg    <= 1'b0;
            answer_reg    <= '0;
            answered_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                win_cfg_reg <= cfg_wr_data;
            end
            pos_reg       <= pos_next;
            tx_active_reg <= tx_active_next;
            busy_reg      <= busy_next;
            lvl_a_reg     <= lvl_a_next;
            lvl_b_reg     <= lvl_b_next;
            fwd_a_reg     <= fwd_a_next;
            fwd_b_reg     <= fwd_b_next;
            rx_pos_reg    <= rx_pos_next;
            rx_active_reg <= rx_active_next;
            rx_shift_reg  <= rx_shift_next;
            pol_reg       <= pol_next;
            win_reg       <= win_next;
            held_a_reg    <= held_a_next;
            held_b_reg    <= held_b_next;
            answer_reg    <= answer_next;
            answered_reg  <= answered_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(result_reg);

endmodule

`default_nettype wire

// File: sv/dali_dual_master_tx_rx.sv
// top level of the two-line dali master with shared answer receiver
//
// channel   direction  payload
// s_axis    in         tuser[1:0] mode, tdata frames and receive level
// m_axis    out        tdata line levels, busy, answer byte and pulses
// cfg       in         answer window length in half-bit ticks
//
// one transaction per clock sustained while the output is not stalled; an item
// passes through the input register, then the result register.
// a held input item lets the input side take one more transaction while a
// result waits on a stalled output.
// reset clears all transfer state; the answer window register resets to 27.
`timescale 1ns / 1ps
`default_nettype none

module dali_dual_master_tx_rx (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // tdata: [15:0] frame_line_a, [31:16] frame_line_b, [32] rx_level, rest zero
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [dali_dm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: [1:0] mode
    input  wire logic [1:0]                          s_axis_tuser,
    // tdata: [0] line_a_level, [1] line_b_level, [2] busy_res,
    //        [10:3] answer_byte, [11] answer_valid, [12] no_answer, rest zero
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [dali_dm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [dali_dm_pkg::WIN_W-1:0]       cfg_wr_data
);
    import dali_dm_pkg::*;

    item_bus_t item_bus;
    logic      advance;

    // input register
    dali_dm_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .item_bus      (item_bus)
    );

    // state update and result register
    dali_dm_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .item_bus      (item_bus),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire
